// ===== rtl/core/rmsr_pkg.sv =====
// shared constants and controller/datapath interface types for the row min/max swapper
`default_nettype none

package rmsr_pkg;

    // parameter defaults
    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_ROWS_DEF = 1024;

    // field widths
    localparam int VALUE_W = 16;
    localparam int COLS_W  = 5;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 10;

    // column register value after reset
    localparam logic [COLS_W-1:0] COLS_RESET = 5'd16;

    // commands from controller to datapath
    typedef struct packed {
        logic take;     // input item accepted this cycle
        logic finish;   // settle row range and best row
        logic read;     // read one buffered element
        logic pop;      // result item taken downstream
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic row_end;  // current input item closes the row
        logic last_col; // element on show is the row's last
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmsr_ctrl.sv =====
// controller state machine: accept, finish, then read and show each row element
`default_nettype none

module rmsr_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rmsr_pkg::dp_sts_t sts,
    output rmsr_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIN,
        S_READ,
        S_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // commands follow the state directly
    always_comb
    begin
        cmd.take   = in_valid & in_ready_reg;
        cmd.finish = (state_reg == S_FIN);
        cmd.read   = (state_reg == S_READ);
        cmd.pop    = (state_reg == S_SHOW) & out_ready;
    end

    // next state and registered handshake outputs
    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && sts.row_end)
                begin
                    state_next    = S_FIN;
                    in_ready_next = 1'b0;
                end
            end
            S_FIN:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next     = S_SHOW;
                out_valid_next = 1'b1;
            end
            S_SHOW:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (sts.last_col)
                    begin
                        state_next    = S_IDLE;
                        in_ready_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmsr_dp.sv =====
// datapath: row buffer memory, min/max tracking, row range, best row and counters
`default_nettype none

module rmsr_dp
#(
    parameter int MAX_COLS = rmsr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = rmsr_pkg::MAX_ROWS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic        [rmsr_pkg::COLS_W-1:0]   cfg_data,
    input  wire logic signed [rmsr_pkg::VALUE_W-1:0]  value,
    input  wire logic                                 end_of_matrix,
    input  wire rmsr_pkg::dp_cmd_t                    cmd,
    output rmsr_pkg::dp_sts_t                         sts,
    output logic signed      [rmsr_pkg::VALUE_W-1:0]  value_res,
    output logic             [rmsr_pkg::COL_W-1:0]    col_index,
    output logic             [rmsr_pkg::ROW_W-1:0]    row_index,
    output logic             [rmsr_pkg::VALUE_W-1:0]  row_diff,
    output logic                                      last_of_row,
    output logic             [rmsr_pkg::ROW_W-1:0]    best_row,
    output logic             [rmsr_pkg::VALUE_W-1:0]  best_diff,
    output logic                                      last_of_matrix
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW = (CW > rmsr_pkg::COLS_W) ? CW : rmsr_pkg::COLS_W;
    localparam int VW = rmsr_pkg::VALUE_W;

    localparam logic [EW-1:0] EFF_MAX  = EW'(MAX_COLS);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    // row buffer
    logic signed [VW-1:0] row_mem [MAX_COLS];
    logic signed [VW-1:0] rdata_reg;

    logic [rmsr_pkg::COLS_W-1:0] cols_reg;
    logic [CW-1:0]               col_reg;
    logic [CW-1:0]               n_reg;
    logic [AW-1:0]               k_reg;
    logic [RW-1:0]               row_reg;
    logic signed [VW-1:0]        min_reg;
    logic signed [VW-1:0]        max_reg;
    logic [AW-1:0]               min_pos_reg;
    logic [AW-1:0]               max_pos_reg;
    logic [VW-1:0]               diff_reg;
    logic [VW-1:0]               best_diff_reg;
    logic [RW-1:0]               best_row_reg;
    logic                        eom_reg;

    logic [EW-1:0] cols_ext;
    logic [EW-1:0] eff_cols;
    logic [CW-1:0] cnt_inc;
    logic [VW-1:0] diff_now;
    logic [31:0]   k_wide;
    logic [31:0]   row_wide;
    logic [31:0]   best_wide;

    // effective row length, clamped into 1..MAX_COLS
    always_comb
    begin
        cols_ext = EW'(cols_reg);
        if (cols_reg == '0)
            eff_cols = EW'(1);
        else if (cols_ext > EFF_MAX)
            eff_cols = EFF_MAX;
        else
            eff_cols = cols_ext;
    end

    // row end and last element detection
    assign cnt_inc      = col_reg + CW'(1);
    assign sts.row_end  = (EW'(cnt_inc) >= eff_cols);
    assign sts.last_col = ((CW'(k_reg) + CW'(1)) == n_reg);

    // unsigned range; wraps cleanly since max is never below min
    assign diff_now = VW'(max_reg - min_reg);

    // column register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cols_reg <= rmsr_pkg::COLS_RESET;
        else if (cfg_we)
            cols_reg <= cfg_data;
    end

    // row buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            row_mem[col_reg[AW-1:0]] <= value;
        if (cmd.read)
            rdata_reg <= row_mem[k_reg];
    end

    // first minimum and first maximum of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= '0;
            max_reg     <= '0;
            min_pos_reg <= '0;
            max_pos_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (col_reg == '0)
            begin
                min_reg     <= value;
                max_reg     <= value;
                min_pos_reg <= '0;
                max_pos_reg <= '0;
            end
            else
            begin
                if (value < min_reg)
                begin
                    min_reg     <= value;
                    min_pos_reg <= col_reg[AW-1:0];
                end
                if (value > max_reg)
                begin
                    max_reg     <= value;
                    max_pos_reg <= col_reg[AW-1:0];
                end
            end
        end
    end

    // column count, row length and end mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            n_reg   <= '0;
            eom_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (sts.row_end)
            begin
                col_reg <= '0;
                n_reg   <= cnt_inc;
                eom_reg <= end_of_matrix;
            end
            else
            begin
                col_reg <= cnt_inc;
            end
        end
    end

    // row range, best row, burst position and row number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg      <= '0;
            best_diff_reg <= '0;
            best_row_reg  <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                diff_reg <= diff_now;
                if (diff_now > best_diff_reg)
                begin
                    best_diff_reg <= diff_now;
                    best_row_reg  <= row_reg;
                end
            end
            if (cmd.pop)
            begin
                if (sts.last_col)
                begin
                    k_reg <= '0;
                    if (eom_reg)
                    begin
                        row_reg       <= '0;
                        best_diff_reg <= '0;
                        best_row_reg  <= '0;
                    end
                    else if (row_reg != ROW_LAST)
                    begin
                        row_reg <= row_reg + RW'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + AW'(1);
                end
            end
        end
    end

    // result fields, min and max exchanged on the way out
    always_comb
    begin
        k_wide    = 32'(k_reg);
        row_wide  = 32'(row_reg);
        best_wide = 32'(best_row_reg);
        if (k_reg == min_pos_reg)
            value_res = max_reg;
        else if (k_reg == max_pos_reg)
            value_res = min_reg;
        else
            value_res = rdata_reg;
        col_index      = k_wide[rmsr_pkg::COL_W-1:0];
        row_index      = row_wide[rmsr_pkg::ROW_W-1:0];
        best_row       = best_wide[rmsr_pkg::ROW_W-1:0];
        row_diff       = diff_reg;
        best_diff      = best_diff_reg;
        last_of_row    = sts.last_col;
        last_of_matrix = eom_reg & sts.last_col;
    end

endmodule

`default_nettype wire

// ===== rtl/core/row_minmax_swap_range.sv =====
// Elements that do not close a row are taken one per cycle, back to back.
// The element that closes a row starts a burst: a finish state settles the
// range and best row, then each result takes a row buffer read state and a show
// state that holds until out_ready; the next item is taken after the last show.
// No item is taken during a burst. Reset clears counters, min/max, best row and
// sets cols to 16; the row buffer itself is not cleared.
`default_nettype none

module row_minmax_swap_range
#(
    parameter int MAX_COLS = rmsr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = rmsr_pkg::MAX_ROWS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic        [rmsr_pkg::COLS_W-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [rmsr_pkg::VALUE_W-1:0]  value,
    input  wire logic                                 end_of_matrix,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [rmsr_pkg::VALUE_W-1:0]  value_res,
    output logic             [rmsr_pkg::COL_W-1:0]    col_index,
    output logic             [rmsr_pkg::ROW_W-1:0]    row_index,
    output logic             [rmsr_pkg::VALUE_W-1:0]  row_diff,
    output logic                                      last_of_row,
    output logic             [rmsr_pkg::ROW_W-1:0]    best_row,
    output logic             [rmsr_pkg::VALUE_W-1:0]  best_diff,
    output logic                                      last_of_matrix
);

    rmsr_pkg::dp_cmd_t cmd;
    rmsr_pkg::dp_sts_t sts;

    // sequencing
    rmsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // row buffer and arithmetic
    rmsr_dp
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .value          (value),
        .end_of_matrix  (end_of_matrix),
        .cmd            (cmd),
        .sts            (sts),
        .value_res      (value_res),
        .col_index      (col_index),
        .row_index      (row_index),
        .row_diff       (row_diff),
        .last_of_row    (last_of_row),
        .best_row       (best_row),
        .best_diff      (best_diff),
        .last_of_matrix (last_of_matrix)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rmsr_chk.sv =====
// port-level checks for the row min/max swapper, bound to the top level
`default_nettype none

module rmsr_chk
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [rmsr_pkg::COL_W-1:0]      col_index,
    input wire logic [rmsr_pkg::VALUE_W-1:0]    row_diff,
    input wire logic                            last_of_row,
    input wire logic [rmsr_pkg::VALUE_W-1:0]    best_diff,
    input wire logic                            last_of_matrix
);

    // input side closed while a burst is on show
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is shown");

    // matrix end only on a row end
    a_eom_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_matrix) |-> last_of_row)
        else $error("last_of_matrix without last_of_row");

    // best range covers the row being shown
    a_best_covers_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_diff >= row_diff))
        else $error("best_diff below row_diff");

    // next element of a burst follows a read state with out_valid low, one column on
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_row) |=>
            !out_valid ##1 (out_valid && (col_index == $past(col_index, 2) + 4'd1)))
        else $error("burst column sequence broken");

    // input reopens right after the last item of a row is taken
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_row) |=> in_ready)
        else $error("input not reopened after row burst");

endmodule

bind row_minmax_swap_range rmsr_chk u_chk (.*);

`default_nettype wire

// ===== tb/swap_range_checker.sv =====
// checker for the row min/max swapper: predicts each swapped row and compares it field by field
module swap_range_checker
    import rmsr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [COLS_W-1:0]          cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       end_of_matrix,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [VALUE_W-1:0]  value_res,
    input  logic [COL_W-1:0]           col_index,
    input  logic [ROW_W-1:0]           row_index,
    input  logic [VALUE_W-1:0]         row_diff,
    input  logic                       last_of_row,
    input  logic [ROW_W-1:0]           best_row,
    input  logic [VALUE_W-1:0]         best_diff,
    input  logic                       last_of_matrix,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ROW_W-1:0] ROW_CEILING = ROW_W'(MAX_ROWS_DEF - 1);

    // one emitted element of a finished row
    typedef struct packed {
        logic signed [VALUE_W-1:0] elem;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic [VALUE_W-1:0]        span;
        logic                      row_last;
        logic [ROW_W-1:0]          widest_row;
        logic [VALUE_W-1:0]        widest_span;
        logic                      matrix_last;
    } swapped_elem_t;

    // predictor state
    logic [COLS_W-1:0]         cols_reg;
    logic signed [VALUE_W-1:0] row_buf [MAX_COLS_DEF];
    int                        fill;
    logic signed [VALUE_W-1:0] lo_val;
    logic signed [VALUE_W-1:0] hi_val;
    int                        lo_col;
    int                        hi_col;
    logic [ROW_W-1:0]          row_num;
    logic [ROW_W-1:0]          widest_row_num;
    logic [VALUE_W-1:0]        widest_span;
    swapped_elem_t             swapped_q [$];
    int                        fails;

    // row length actually in force, with out-of-range settings clamped
    function automatic int row_len();
        if (cols_reg == '0)
            return 1;
        if (cols_reg > COLS_W'(MAX_COLS_DEF))
            return MAX_COLS_DEF;
        return int'(cols_reg);
    endfunction

    // take one element; at row end queue the swapped row
    function automatic void fold_element(input logic signed [VALUE_W-1:0] v, input logic mark);
        int                        n;
        logic [VALUE_W-1:0]        span;
        logic signed [VALUE_W-1:0] e;
        swapped_elem_t             s;

        if (fill >= MAX_COLS_DEF)
            fill = 0;
        row_buf[fill] = v;
        if (fill == 0)
        begin
            lo_val = v;
            lo_col = 0;
            hi_val = v;
            hi_col = 0;
        end
        else
        begin
            // strict compares keep the first minimum and maximum
            if (v < lo_val)
            begin
                lo_val = v;
                lo_col = fill;
            end
            if (v > hi_val)
            begin
                hi_val = v;
                hi_col = fill;
            end
        end
        fill++;
        if (fill < row_len())
            return;

        n = fill;
        fill = 0;
        span = hi_val - lo_val;
        if (span > widest_span)
        begin
            widest_span = span;
            widest_row_num = row_num;
        end

        for (int k = 0; k < n; k++)
        begin
            e = row_buf[k];
            if (k == lo_col)
                e = hi_val;
            else if (k == hi_col)
                e = lo_val;
            s.elem        = e;
            s.col         = COL_W'(k);
            s.row         = row_num;
            s.span        = span;
            s.row_last    = (k == n - 1);
            s.widest_row  = widest_row_num;
            s.widest_span = widest_span;
            s.matrix_last = mark && (k == n - 1);
            swapped_q.push_back(s);
        end

        // matrix end starts the row count and best row afresh
        if (mark)
        begin
            row_num = '0;
            widest_span = '0;
            widest_row_num = '0;
        end
        else if (row_num != ROW_CEILING)
        begin
            row_num++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    // compare one result item with the oldest expectation
    function automatic void check_result();
        swapped_elem_t want;

        if (swapped_q.size() == 0)
        begin
            $error("result item with none expected: value_res 0x%0h col_index %0d",
                   value_res, col_index);
            fails++;
            return;
        end
        want = swapped_q.pop_front();
        check_field("value_res", want.elem, value_res);
        check_field("col_index", VALUE_W'(want.col), VALUE_W'(col_index));
        check_field("row_index", VALUE_W'(want.row), VALUE_W'(row_index));
        check_field("row_diff", want.span, row_diff);
        check_field("last_of_row", VALUE_W'(want.row_last), VALUE_W'(last_of_row));
        check_field("best_row", VALUE_W'(want.widest_row), VALUE_W'(best_row));
        check_field("best_diff", want.widest_span, best_diff);
        check_field("last_of_matrix", VALUE_W'(want.matrix_last), VALUE_W'(last_of_matrix));
    endfunction

    // watch the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg = COLS_RESET;
            fill = 0;
            lo_val = '0;
            hi_val = '0;
            lo_col = 0;
            hi_col = 0;
            row_num = '0;
            widest_row_num = '0;
            widest_span = '0;
            swapped_q.delete();
            fails = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                cols_reg = cfg_data;
            if (in_valid && in_ready)
                fold_element(value, end_of_matrix);
            if (out_valid && out_ready)
                check_result();
            errors <= fails;
            pending <= swapped_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// top of the row min/max swapper testbench: clock, reset, stimulus, receiver and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmsr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    localparam logic signed [VALUE_W-1:0] V_MIN = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 16'sh7FFF;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [COLS_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      end_of_matrix = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] value_res;
    logic [COL_W-1:0]          col_index;
    logic [ROW_W-1:0]          row_index;
    logic [VALUE_W-1:0]        row_diff;
    logic                      last_of_row;
    logic [ROW_W-1:0]          best_row;
    logic [VALUE_W-1:0]        best_diff;
    logic                      last_of_matrix;

    int   errors;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_trig = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    row_minmax_swap_range DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .end_of_matrix  (end_of_matrix),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_res      (value_res),
        .col_index      (col_index),
        .row_index      (row_index),
        .row_diff       (row_diff),
        .last_of_row    (last_of_row),
        .best_row       (best_row),
        .best_diff      (best_diff),
        .last_of_matrix (last_of_matrix)
    );

    swap_range_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .end_of_matrix  (end_of_matrix),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_res      (value_res),
        .col_index      (col_index),
        .row_index      (row_index),
        .row_diff       (row_diff),
        .last_of_row    (last_of_row),
        .best_row       (best_row),
        .best_diff      (best_diff),
        .last_of_matrix (last_of_matrix),
        .errors         (errors),
        .pending        (pending)
    );

    // receiver: random stalls, or a long hold-off when asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_trig != hold_seen)
        begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // element values biased towards the extremes and towards ties
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] raw;

        case ($urandom_range(9))
            0:       raw = V_MIN;
            1:       raw = V_MAX;
            2, 3:    raw = VALUE_W'($urandom_range(6)) - VALUE_W'(3);
            default: raw = VALUE_W'($urandom());
        endcase
        return raw;
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic mark);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        end_of_matrix <= mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // whole rows of random content; a stray mark now and then mid-row
    task automatic send_rows(input int rows, input int len, input int mark_pct);
        logic mark;

        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < len; c++)
            begin
                if (c == len - 1)
                    mark = ($urandom_range(99) < mark_pct);
                else
                    mark = ($urandom_range(29) == 0);
                send_item(pick_value(), mark);
            end
        end
    endtask

    // stop offering items and wait until every expected result is in
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_cols(input logic [COLS_W-1:0] c);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int len;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full row at the reset width: extremes, repeated min and max, stray mark
        send_item(16'sd5, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(V_MIN, 1'b0);
        send_item(16'sd1, 1'b0);
        send_item(V_MAX, 1'b0);
        send_item(16'sd7, 1'b0);
        send_item(-16'sd300, 1'b1);
        send_item(16'sd2, 1'b0);
        send_item(V_MIN, 1'b0);
        send_item(16'sd9, 1'b0);
        send_item(16'sd1234, 1'b0);
        send_item(V_MAX, 1'b0);
        send_item(-16'sd2, 1'b0);
        send_item(16'sd3, 1'b0);
        send_item(16'sh5555, 1'b0);

        // zero width acts as one: single element row closing the matrix
        set_cols(5'd0);
        send_item(16'sd5, 1'b1);

        // flat row: min and max share a column, zero range
        set_cols(5'd2);
        send_item(16'sd100, 1'b0);
        send_item(16'sd100, 1'b1);

        // oversized width acts as 16, then lowered under a partly filled row
        set_cols(5'd31);
        send_item(-16'sd20, 1'b0);
        send_item(16'sd40, 1'b0);
        send_item(16'sd40, 1'b0);
        send_item(-16'sd20, 1'b0);
        set_cols(5'd3);
        send_item(16'sd11, 1'b0);

        // short rows, no idling
        set_cols(5'd4);
        send_rows(6, 4, 25);

        // single element rows, idle sender
        set_cols(5'd1);
        send_idle_pct = 56;
        send_rows(12, 1, 20);

        // widest rows from an over-range setting, stalling receiver
        set_cols(5'd17);
        send_idle_pct = 0;
        stall_pct <= 56;
        send_rows(2, 16, 50);

        // random width, both sides idling
        len = $urandom_range(2, 15);
        set_cols(COLS_W'(len));
        send_idle_pct = 38;
        stall_pct <= 38;
        send_rows(20 / len + 1, len, 25);

        // receiver holds off for a long stretch while rows are offered; input stays closed meanwhile
        set_cols(5'd3);
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_trig <= ~hold_trig;
        send_rows(6, 3, 20);

        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rmsr_pkg.sv
rtl/core/rmsr_ctrl.sv
rtl/core/rmsr_dp.sv
rtl/core/row_minmax_swap_range.sv
rtl/core/rmsr_chk.sv
tb/swap_range_checker.sv
tb/testbench.sv
